// File: sv/decimal_text_to_clamped_int_unit_macros.svh
`ifndef DECIMAL_TEXT_TO_CLAMPED_INT_UNIT_MACROS_SVH
`define DECIMAL_TEXT_TO_CLAMPED_INT_UNIT_MACROS_SVH

// Same-cycle implication, checked on aclk outside reset.
`define DTCI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk outside reset.
`define DTCI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/dtci_pkg.sv
`timescale 1ns / 1ps

package dtci_pkg;

    localparam int CHAR_WIDTH  = 8;
    localparam int BOUND_WIDTH = 32;
    localparam int CFG_INDEX_WIDTH = 1;

    localparam logic [CHAR_WIDTH-1:0] CHAR_TAB   = 8'd9;
    localparam logic [CHAR_WIDTH-1:0] CHAR_CR    = 8'd13;
    localparam logic [CHAR_WIDTH-1:0] CHAR_SPACE = 8'd32;
    localparam logic [CHAR_WIDTH-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CHAR_NINE  = 8'h39;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_CLAMP_LOW  = 1'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_CLAMP_HIGH = 1'd1;

    localparam logic [BOUND_WIDTH-1:0] CLAMP_LOW_RESET  = 32'h0000_0000;
    localparam logic [BOUND_WIDTH-1:0] CLAMP_HIGH_RESET = 32'h7FFF_FFFF;

    typedef enum logic [5:0] {
        PH_LEAD   = 6'b000001,
        PH_SIGN   = 6'b000010,
        PH_DIGITS = 6'b000100,
        PH_TRAIL  = 6'b001000,
        PH_LOCKED = 6'b010000,
        PH_BAD    = 6'b100000
    } phase_t;

    function automatic logic is_blank(input logic [CHAR_WIDTH-1:0] c);
        return ((c >= CHAR_TAB) && (c <= CHAR_CR)) || (c == CHAR_SPACE);
    endfunction

    function automatic logic is_digit(input logic [CHAR_WIDTH-1:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

endpackage

// File: sv/decimal_text_to_clamped_int_unit.sv
`timescale 1ns / 1ps

// Channel   Dir  Payload                                   Handshake
// s_*       in   tdata[7:0] char_code, tlast last_char     s_tvalid / s_tready
// m_*       out  tdata[31:0] clamped_value, tuser parse_ok m_tvalid / m_tready
// cfg_*     in   cfg_index (0 low, 1 high), cfg_data       cfg_valid / cfg_ready
//
// One character per cycle while the result path is not stalled; a result then moves through the stages below.
// Stages: input register, parse state update, clamp into the output register.
// Each stage holds only while the one after it is full and stalled.
// aresetn (synchronous) clears the parse state and all valid flags and resets the bounds to their defaults.
// cfg_ready is always high.

module decimal_text_to_clamped_int_unit #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [dtci_pkg::CHAR_WIDTH-1:0]      s_tdata,   // [7:0] char_code
    input  logic                                 s_tlast,   // last_char
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [dtci_pkg::BOUND_WIDTH-1:0]     m_tdata,   // [31:0] clamped_value
    output logic [0:0]                           m_tuser,   // [0] parse_ok
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [dtci_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [dtci_pkg::BOUND_WIDTH-1:0]     cfg_data
);
    import dtci_pkg::*;

    localparam int VW = VALUE_WIDTH;
    localparam int PW = VALUE_WIDTH + 4;
    localparam int CW = ((VALUE_WIDTH > BOUND_WIDTH) ? VALUE_WIDTH : BOUND_WIDTH) + 1;

    logic [BOUND_WIDTH-1:0] clamp_low_reg;
    logic [BOUND_WIDTH-1:0] clamp_high_reg;

    logic                  in_valid_reg;
    logic [CHAR_WIDTH-1:0] in_char_reg;
    logic                  in_last_reg;

    phase_t        phase_reg, phase_next;
    logic          neg_reg, neg_next;
    logic          plus_reg, plus_next;
    logic [VW-1:0] mag_reg, mag_next;
    logic          ovf_reg, ovf_next;

    logic          fin_valid_reg;
    logic          fin_ok_reg;
    logic          fin_neg_reg;
    logic [VW-1:0] fin_mag_reg;

    logic                   out_valid_reg;
    logic                   out_ok_reg;
    logic [BOUND_WIDTH-1:0] out_value_reg;

    logic out_ready, fin_ready, in_go;
    logic [VW-1:0] cap;
    logic [PW-1:0] prod;
    logic          digit, blank;
    logic [3:0]    digit_val;
    logic [VW-1:0] acc_mag;
    logic          acc_ovf;

    logic signed [VW:0]   signed_val;
    logic signed [CW-1:0] val_ext, lo_ext, hi_ext, clamped;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clamp_low_reg  <= CLAMP_LOW_RESET;
            clamp_high_reg <= CLAMP_HIGH_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_CLAMP_LOW:  clamp_low_reg  <= cfg_data;
                REG_CLAMP_HIGH: clamp_high_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign out_ready = !out_valid_reg || m_tready;
    assign fin_ready = !fin_valid_reg || out_ready;
    assign in_go     = in_valid_reg && (!in_last_reg || fin_ready);
    assign s_tready  = !in_valid_reg || in_go;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready) begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Accumulate one digit, saturating at the signed range of the current sign.
    always_comb begin
        digit     = is_digit(in_char_reg);
        blank     = is_blank(in_char_reg);
        digit_val = in_char_reg[3:0];
        cap       = neg_reg ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
        prod      = ({4'd0, mag_reg} << 3) + ({4'd0, mag_reg} << 1)
                    + {{(PW-4){1'b0}}, digit_val};
        acc_mag   = mag_reg;
        acc_ovf   = ovf_reg;
        if (!ovf_reg) begin
            if (prod > {4'd0, cap}) begin
                acc_ovf = 1'b1;
                acc_mag = cap;
            end else begin
                acc_mag = prod[VW-1:0];
            end
        end
    end

    always_comb begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        plus_next  = plus_reg;
        mag_next   = mag_reg;
        ovf_next   = ovf_reg;
        unique case (phase_reg)
            PH_LEAD: begin
                if (blank) begin
                    phase_next = PH_LEAD;
                end else if (in_char_reg == CHAR_PLUS) begin
                    plus_next  = 1'b1;
                    phase_next = PH_SIGN;
                end else if (in_char_reg == CHAR_MINUS) begin
                    neg_next   = 1'b1;
                    phase_next = PH_SIGN;
                end else if (digit) begin
                    mag_next   = acc_mag;
                    ovf_next   = acc_ovf;
                    phase_next = PH_DIGITS;
                end else begin
                    phase_next = PH_BAD;
                end
            end
            PH_SIGN: begin
                if (digit) begin
                    mag_next   = acc_mag;
                    ovf_next   = acc_ovf;
                    phase_next = PH_DIGITS;
                end else begin
                    phase_next = PH_BAD;
                end
            end
            PH_DIGITS: begin
                if (digit) begin
                    mag_next = acc_mag;
                    ovf_next = acc_ovf;
                end else if (ovf_reg && !plus_reg) begin
                    phase_next = PH_LOCKED;
                end else if (blank) begin
                    phase_next = PH_TRAIL;
                end else begin
                    phase_next = PH_BAD;
                end
            end
            PH_TRAIL: begin
                if (!blank) begin
                    phase_next = PH_BAD;
                end
            end
            PH_LOCKED: phase_next = PH_LOCKED;
            PH_BAD:    phase_next = PH_BAD;
            default:   phase_next = PH_BAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_LEAD;
            neg_reg   <= 1'b0;
            plus_reg  <= 1'b0;
            mag_reg   <= '0;
            ovf_reg   <= 1'b0;
        end else if (in_go) begin
            if (in_last_reg) begin
                phase_reg <= PH_LEAD;
                neg_reg   <= 1'b0;
                plus_reg  <= 1'b0;
                mag_reg   <= '0;
                ovf_reg   <= 1'b0;
            end else begin
                phase_reg <= phase_next;
                neg_reg   <= neg_next;
                plus_reg  <= plus_next;
                mag_reg   <= mag_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_valid_reg <= 1'b0;
        end else if (fin_ready) begin
            fin_valid_reg <= in_go && in_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fin_ready) begin
            fin_ok_reg  <= (phase_next == PH_DIGITS) || (phase_next == PH_TRAIL)
                           || (phase_next == PH_LOCKED);
            fin_neg_reg <= neg_next;
            fin_mag_reg <= mag_next;
        end
    end

    // Inverted bounds: values below the low bound give the low bound, all others give the high bound.
    always_comb begin
        signed_val = fin_neg_reg ? -$signed({1'b0, fin_mag_reg}) : $signed({1'b0, fin_mag_reg});
        val_ext    = CW'(signed_val);
        lo_ext     = CW'($signed(clamp_low_reg));
        hi_ext     = CW'($signed(clamp_high_reg));
        if (val_ext < lo_ext) begin
            clamped = lo_ext;
        end else if (val_ext > hi_ext) begin
            clamped = hi_ext;
        end else begin
            clamped = val_ext;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= fin_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready) begin
            out_ok_reg    <= fin_ok_reg;
            out_value_reg <= fin_ok_reg ? clamped[BOUND_WIDTH-1:0] : '0;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_value_reg;
    assign m_tuser[0] = out_ok_reg;

`include "decimal_text_to_clamped_int_unit_macros.svh"

    `DTCI_ASSERT_NOW(a_fail_is_zero, m_tvalid && !m_tuser[0], m_tdata == '0, "failed parse with nonzero value")
    `DTCI_ASSERT_NOW(a_lead_clean, phase_reg == PH_LEAD, (mag_reg == '0) && !neg_reg && !plus_reg && !ovf_reg, "leading phase with stale field state")
    `DTCI_ASSERT_NOW(a_ovf_saturated, ovf_reg, mag_reg == cap, "overflow without saturated magnitude")
    `DTCI_ASSERT_NEXT(a_last_clears, in_go && in_last_reg, phase_reg == PH_LEAD, "field state not cleared after last char")
    `DTCI_ASSERT_NOW(a_in_bounds, m_tvalid && m_tuser[0] && ($signed(clamp_low_reg) <= $signed(clamp_high_reg)), ($signed(m_tdata) >= $signed(clamp_low_reg)) && ($signed(m_tdata) <= $signed(clamp_high_reg)), "result outside clamp bounds")

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import dtci_pkg::*;

    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          SETTLE_CYCLES  = 10;
    localparam int          HOLDOFF_CYCLES = 300;
    localparam logic [31:0] INT_MIN_BITS   = 32'h8000_0000;
    localparam logic [31:0] INT_MAX_BITS   = 32'h7FFF_FFFF;

    typedef logic [7:0] text_t[$];

    typedef struct packed {
        logic        ok;
        logic [31:0] value;
    } int_result_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;   // [7:0] char_code
    logic        s_tlast   = 1'b0; // last_char
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;          // [31:0] clamped_value
    logic [0:0]  m_tuser;          // [0] parse_ok
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;

    decimal_text_to_clamped_int_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // parser model state
    phase_t             fld_phase = PH_LEAD;
    bit                 fld_neg   = 1'b0;
    bit                 fld_plus  = 1'b0;
    bit                 fld_ovf   = 1'b0;
    logic [63:0]        fld_mag   = '0;
    logic signed [31:0] bound_low  = CLAMP_LOW_RESET;
    logic signed [31:0] bound_high = CLAMP_HIGH_RESET;

    int_result_t expected_ints[$];

    int src_idle_pct    = 0;
    int sink_stall_pct  = 0;
    int holdoff_request = 0;
    int holdoff_left    = 0;
    int quiet_cycles    = 0;
    int mismatches      = 0;
    int chars_sent      = 0;
    int fields_sent     = 0;
    int results_seen    = 0;
    int bound_settings  = 0;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic bit space_char(logic [7:0] c);
        return ((c >= CHAR_TAB) && (c <= CHAR_CR)) || (c == CHAR_SPACE);
    endfunction

    function automatic bit decimal_char(logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    function automatic void accumulate_digit(logic [7:0] c);
        logic [63:0] cap;
        logic [63:0] d;
        cap = fld_neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        d   = 64'(c - CHAR_ZERO);
        if (fld_ovf)
            return;
        if (fld_mag > (cap - d) / 10) begin
            fld_ovf = 1'b1;
            fld_mag = cap;
        end else begin
            fld_mag = fld_mag * 10 + d;
        end
    endfunction

    function automatic void parse_char(logic [7:0] c);
        case (fld_phase)
            PH_LEAD: begin
                if (space_char(c)) begin
                end else if (c == CHAR_PLUS) begin
                    fld_plus  = 1'b1;
                    fld_phase = PH_SIGN;
                end else if (c == CHAR_MINUS) begin
                    fld_neg   = 1'b1;
                    fld_phase = PH_SIGN;
                end else if (decimal_char(c)) begin
                    accumulate_digit(c);
                    fld_phase = PH_DIGITS;
                end else begin
                    fld_phase = PH_BAD;
                end
            end
            PH_SIGN: begin
                if (decimal_char(c)) begin
                    accumulate_digit(c);
                    fld_phase = PH_DIGITS;
                end else begin
                    fld_phase = PH_BAD;
                end
            end
            PH_DIGITS: begin
                if (decimal_char(c))
                    accumulate_digit(c);
                else if (fld_ovf && !fld_plus)
                    fld_phase = PH_LOCKED;
                else if (space_char(c))
                    fld_phase = PH_TRAIL;
                else
                    fld_phase = PH_BAD;
            end
            PH_TRAIL: begin
                if (!space_char(c))
                    fld_phase = PH_BAD;
            end
            PH_LOCKED: begin
            end
            default: fld_phase = PH_BAD;
        endcase
    endfunction

    function automatic int_result_t close_field();
        int_result_t        r;
        logic signed [63:0] v;
        logic signed [63:0] lo;
        logic signed [63:0] hi;
        lo   = bound_low;
        hi   = bound_high;
        r.ok = (fld_phase == PH_DIGITS) || (fld_phase == PH_TRAIL) ||
               (fld_phase == PH_LOCKED);
        v = fld_neg ? -$signed(fld_mag) : $signed(fld_mag);
        if (v < lo)
            v = lo;
        else if (v > hi)
            v = hi;
        r.value   = r.ok ? v[31:0] : 32'd0;
        fld_phase = PH_LEAD;
        fld_neg   = 1'b0;
        fld_plus  = 1'b0;
        fld_ovf   = 1'b0;
        fld_mag   = '0;
        return r;
    endfunction

    // driving happens at the falling edge; every task starts and ends there
    task automatic send_char(input logic [7:0] c, input bit last);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = c;
        s_tlast  = last;
        do @(posedge aclk); while (!s_tready);
        parse_char(c);
        if (last)
            expected_ints.push_back(close_field());
        chars_sent++;
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic send_field(input text_t t);
        foreach (t[i])
            send_char(t[i], i == t.size() - 1);
        fields_sent++;
    endtask

    task automatic send_text(input string s);
        text_t t;
        for (int i = 0; i < s.len(); i++)
            t.push_back(s[i]);
        send_field(t);
    endtask

    task automatic wait_idle();
        while (expected_ints.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_bounds(input logic [31:0] lo, input logic [31:0] hi);
        wait_idle();
        cfg_valid = 1'b1;
        cfg_index = REG_CLAMP_LOW;
        cfg_data  = lo;
        do @(posedge aclk); while (!cfg_ready);
        bound_low = lo;
        @(negedge aclk);
        cfg_index = REG_CLAMP_HIGH;
        cfg_data  = hi;
        do @(posedge aclk); while (!cfg_ready);
        bound_high = hi;
        @(negedge aclk);
        cfg_valid = 1'b0;
        bound_settings++;
    endtask

    function automatic logic [7:0] blank_char();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? CHAR_SPACE : 8'(CHAR_TAB + r);
    endfunction

    function automatic void push_digits(ref text_t t, input int n);
        repeat (n) t.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
    endfunction

    function automatic text_t number_text();
        text_t t;
        int    shape;
        string near_max;
        near_max = "214748364";
        repeat ($urandom_range(0, 2)) t.push_back(blank_char());
        case ($urandom_range(0, 3))
            0: t.push_back(CHAR_PLUS);
            1: t.push_back(CHAR_MINUS);
            default: ;
        endcase
        shape = $urandom_range(0, 9);
        if (shape == 8) begin
            for (int i = 0; i < near_max.len(); i++)
                t.push_back(near_max[i]);
            t.push_back(8'(CHAR_ZERO + $urandom_range(6, 9)));
        end else if (shape <= 5) begin
            push_digits(t, $urandom_range(1, 6));
        end else if (shape <= 7) begin
            push_digits(t, $urandom_range(7, 10));
        end else begin
            push_digits(t, $urandom_range(11, 16));
        end
        repeat ($urandom_range(0, 2)) t.push_back(blank_char());
        return t;
    endfunction

    function automatic text_t broken_text();
        text_t t;
        case ($urandom_range(0, 5))
            0: begin
                t = number_text();
                t[$urandom_range(0, t.size() - 1)] = 8'($urandom);
            end
            1: begin
                t = number_text();
                t.insert($urandom_range(0, t.size()), 8'($urandom));
            end
            2: begin
                // overflowing run followed by junk
                if ($urandom_range(0, 1))
                    t.push_back(CHAR_PLUS);
                push_digits(t, $urandom_range(11, 14));
                repeat ($urandom_range(1, 3)) t.push_back(8'($urandom));
            end
            3: repeat ($urandom_range(1, 4)) t.push_back(8'($urandom));
            4: repeat ($urandom_range(1, 3)) t.push_back(blank_char());
            default: begin
                t.push_back($urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS);
                if ($urandom_range(0, 1))
                    t.push_back(blank_char());
            end
        endcase
        return t;
    endfunction

    task automatic send_random_fields(input int target_chars);
        int start;
        start = chars_sent;
        while (chars_sent - start < target_chars)
            send_field(($urandom_range(0, 3) != 0) ? number_text() : broken_text());
    endtask

    task automatic test_directed_fields();
        text_t t;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        send_text("0");
        send_text("123");
        send_text("-5");
        send_text("+7");
        send_text("  42 \t");
        send_text("\013\014\0159\n");
        send_text("0007");
        send_text("2147483647");
        send_text("2147483648");
        send_text("99999999999x");
        send_text("+99999999999 ");
        send_text("+99999999999x");
        send_text("-");
        send_text("+");
        send_text(" ");
        send_text("12a");
        send_text("1 2");
        send_text("+-1");
        send_text("a");
        t = {};
        t.push_back(8'hFF);
        send_field(t);
        t = {};
        t.push_back(CHAR_ZERO + 8'd5);
        t.push_back(8'h80);
        send_field(t);
        t = {};
        t.push_back(8'h00);
        send_field(t);
    endtask

    task automatic test_bound_extremes();
        logic [31:0] lows[6];
        logic [31:0] highs[6];
        lows  = '{INT_MIN_BITS, INT_MAX_BITS, INT_MIN_BITS, INT_MAX_BITS,
                  -32'sd1000, 32'sd50};
        highs = '{INT_MAX_BITS, INT_MIN_BITS, INT_MIN_BITS, INT_MAX_BITS,
                  32'sd1000, -32'sd50};
        for (int i = 0; i < 6; i++) begin
            set_bounds(lows[i], highs[i]);
            send_text("-2147483648");
            send_text("2147483647");
            send_text("-60");
            send_text("-99999999999");
            send_random_fields(8);
        end
    endtask

    task automatic test_idle_mixes();
        int          src_pcts[4];
        int          sink_pcts[4];
        logic [31:0] lo;
        logic [31:0] hi;
        src_pcts  = '{0, 62, 0, 31};
        sink_pcts = '{0, 0, 62, 31};
        for (int i = 0; i < 4; i++) begin
            case ($urandom_range(0, 2))
                0: begin
                    lo = $urandom;
                    hi = $urandom;
                end
                1: begin
                    lo = 32'd0 - $urandom_range(0, 100000);
                    hi = $urandom_range(0, 100000);
                end
                default: begin
                    lo = INT_MIN_BITS;
                    hi = INT_MAX_BITS;
                end
            endcase
            set_bounds(lo, hi);
            src_idle_pct   = src_pcts[i];
            sink_stall_pct = sink_pcts[i];
            send_random_fields(30);
        end
    endtask

    task automatic test_output_holdoff();
        wait_idle();
        src_idle_pct    = 0;
        sink_stall_pct  = 0;
        holdoff_request = HOLDOFF_CYCLES;
        send_random_fields(40);
    endtask

    task automatic test_sender_pause();
        src_idle_pct   = 20;
        sink_stall_pct = 20;
        send_random_fields(12);
        while (expected_ints.size() != 0)
            @(negedge aclk);
        send_random_fields(12);
    endtask

    // result sink: random stalls plus one long hold-off on request
    always @(negedge aclk) begin
        if (holdoff_request > 0) begin
            holdoff_left    = holdoff_request;
            holdoff_request = 0;
        end
        if (holdoff_left > 0) begin
            m_tready = 1'b0;
            holdoff_left--;
        end else begin
            m_tready = ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    always @(posedge aclk) begin
        int_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_ints.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected transaction, parse_ok=%0b clamped_value=%0d",
                         $time, m_tuser[0], $signed(m_tdata));
            end else begin
                want = expected_ints.pop_front();
                if (m_tuser[0] !== want.ok) begin
                    mismatches++;
                    if (mismatches <= 20)
                        $display("%0t: parse_ok expected %0b actual %0b",
                                 $time, want.ok, m_tuser[0]);
                end
                if (m_tdata !== want.value) begin
                    mismatches++;
                    if (mismatches <= 20)
                        $display("%0t: clamped_value expected %0d actual %0d",
                                 $time, $signed(want.value), $signed(m_tdata));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired with %0d results outstanding",
                     $time, expected_ints.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed_fields();
        test_bound_extremes();
        test_idle_mixes();
        test_output_holdoff();
        test_sender_pause();

        wait_idle();
        $display("Run covered %0d fields (%0d characters), %0d results, %0d bound settings,",
                 fields_sent, chars_sent, results_seen, bound_settings);
        $display("four idle mixes, one long output hold-off and one sender drain pause.");
        if (mismatches == 0 && expected_ints.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: decimal_text_to_clamped_int_unit.f
+incdir+sv
sv/dtci_pkg.sv
sv/decimal_text_to_clamped_int_unit.sv
dv/tb_top.sv
